>>> hw/rtl/fpm_pkg.sv
// Package for the console single-precision multiplier.
// Holds the float field constants, the operand clamp and the Booth-defect predicate; no dependencies.
`default_nettype none
package fpm_pkg;

    localparam logic [31:0] FMAX_BITS   = 32'h7F7F_FFFF;
    localparam logic [31:0] INF_BITS    = 32'h7F80_0000;
    localparam logic [31:0] MIN_NORMAL  = 32'h0080_0000;
    localparam logic [31:0] MANT_MASK   = 32'h007F_FFFF;
    localparam logic [31:0] SIGN_BIT    = 32'h8000_0000;
    localparam logic [22:0] DEFECT_MASK = 23'h0002AA;
    localparam logic [9:0]  EXP_BIAS_ADJ = 10'd173;
    localparam logic [8:0]  SHIFT_LIMIT  = 9'd49;

    // Replaces a zero or subnormal exponent by a signed zero and the top exponent by signed Fmax.
    function automatic logic [31:0] clamp_operand(input logic [31:0] x);
        logic [31:0] r;
        begin
            r = x;
            if ((x & INF_BITS) == 32'd0)
            begin
                r = x & SIGN_BIT;
            end
            else if ((x & INF_BITS) == INF_BITS)
            begin
                r = (x & SIGN_BIT) | FMAX_BITS;
            end
            return r;
        end
    endfunction

    // True when the mantissa of the second factor triggers the one-ULP deficit.
    function automatic logic defective_t(input logic [22:0] m);
        logic [3:0] h;
        logic       in_band;
        begin
            h       = m[15:12];
            in_band = (h >= 4'd8) && (h <= 4'd13);
            return ((m & DEFECT_MASK) != 23'd0) || (m[11] != in_band);
        end
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/fpm_ifs.sv
// Handshake interfaces for the operand, result and configuration channels.
// Each carries valid, ready and its payload; no dependencies.
`default_nettype none
interface fpm_operand_if;
    logic        valid;
    logic        ready;
    logic [31:0] operand_s;
    logic [31:0] operand_t;
    modport source (output valid, output operand_s, output operand_t, input ready);
    modport sink (input valid, input operand_s, input operand_t, output ready);
endinterface

interface fpm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] product_bits;
    logic        overflow_flag;
    logic        underflow_flag;
    logic        overflow_sticky;
    logic        underflow_sticky;
    modport source (output valid, output product_bits, output overflow_flag,
                    output underflow_flag, output overflow_sticky,
                    output underflow_sticky, input ready);
    modport sink (input valid, input product_bits, input overflow_flag,
                  input underflow_flag, input overflow_sticky,
                  input underflow_sticky, output ready);
endinterface

interface fpm_cfg_if;
    logic valid;
    logic ready;
    logic round_nearest;
    modport source (output valid, output round_nearest, input ready);
    modport sink (input valid, input round_nearest, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/console_fp32_multiplier_unit.sv
// Top level of the console single-precision multiplier with its flag registers.
// Depends on fpm_pkg and the channel interfaces in fpm_ifs.sv.
//
//   Channel   Direction  Payload
//   operands  sink       operand_s, operand_t
//   result    source     product_bits, overflow/underflow cause and sticky bits
//   cfg       sink       round_nearest
//
// Each item passes three registers: input, significand product, result.
// One item is accepted per cycle while the result is not stalled.
// Reset clears valid bits, cause and sticky flags and selects round toward zero.
// A stalled result holds the whole pipeline; operands are taken again as soon as it is taken.
`default_nettype none
module console_fp32_multiplier_unit
    import fpm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fpm_operand_if.sink operands,
    fpm_result_if.source result,
    fpm_cfg_if.sink     cfg
);

    logic        advance;
    logic        rn_reg;
    logic        a_valid_reg;
    logic [31:0] a_s_reg;
    logic [31:0] a_t_reg;
    logic        b_valid_reg;
    logic [47:0] b_prod_reg;
    logic [8:0]  b_esum_reg;
    logic        b_zero_reg;
    logic        b_sign_reg;
    logic        b_defect_reg;
    logic        r_valid_reg;
    logic [31:0] r_bits_reg;
    logic        c_ovf_reg;
    logic        c_unf_reg;
    logic        s_ovf_reg;
    logic        s_unf_reg;

    logic [31:0] cs;
    logic [31:0] ct;
    logic [47:0] prod_next;

    logic        top;
    logic signed [10:0] eb;
    logic [8:0]  sh;
    logic [5:0]  sh6;
    logic [48:0] mask;
    logic [48:0] base_mask;
    logic        tail_zero;
    logic [48:0] keep;
    logic [48:0] rem;
    logic [48:0] half;
    logic [33:0] mag;
    logic [31:0] p;
    logic        ovf;
    logic        unf;
    logic [31:0] r_bits_next;

    assign advance = !r_valid_reg || result.ready;
    assign operands.ready = advance;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cs = clamp_operand(a_s_reg);
        ct = clamp_operand(a_t_reg);
        prod_next = {24'd0, 1'b1, cs[22:0]} * {24'd0, 1'b1, ct[22:0]};
    end

    always_comb
    begin
        top = b_prod_reg[47];
        eb = $signed({2'b00, b_esum_reg}) + (top ? 11'sd47 : 11'sd46)
             - $signed({1'b0, EXP_BIAS_ADJ});
        base_mask = top ? {25'd0, 24'hFF_FFFF} : {26'd0, 23'h7F_FFFF};
        tail_zero = ({1'b0, b_prod_reg} & base_mask) == 49'd0;
        if (eb < 11'sd1)
        begin
            sh = 9'((top ? 11'sd24 : 11'sd23) + 11'sd1 - eb);
        end
        else
        begin
            sh = top ? 9'd24 : 9'd23;
        end
        sh6  = sh[5:0];
        mask = (49'd1 << sh6) - 49'd1;
        keep = {1'b0, b_prod_reg} >> sh6;
        rem  = {1'b0, b_prod_reg} & mask;
        half = 49'd1 << (sh6 - 6'd1);
        if (rn_reg && ((rem > half) || ((rem == half) && keep[0])))
        begin
            keep = keep + 49'd1;
        end
        if (sh >= SHIFT_LIMIT)
        begin
            mag = 34'd0;
        end
        else if (eb >= 11'sd1)
        begin
            mag = {1'b0, 10'(eb - 11'sd1), 23'd0} + keep[33:0];
        end
        else
        begin
            mag = keep[33:0];
        end

        if (b_zero_reg)
        begin
            p = b_sign_reg ? SIGN_BIT : 32'd0;
        end
        else if (mag >= {2'b00, INF_BITS})
        begin
            p = {b_sign_reg, rn_reg ? INF_BITS[30:0] : FMAX_BITS[30:0]};
        end
        else
        begin
            if (tail_zero && (eb >= 11'sd1) && (eb <= 11'sd254)
                && (mag != {2'b00, MIN_NORMAL}) && b_defect_reg)
            begin
                mag = mag - 34'd1;
            end
            p = {b_sign_reg, mag[30:0]};
        end

        ovf = (p[30:0] == INF_BITS[30:0]);
        unf = !ovf && ((p & INF_BITS) == 32'd0) && ((p & MANT_MASK) != 32'd0);
        if (ovf)
        begin
            r_bits_next = {p[31], FMAX_BITS[30:0]};
        end
        else if (unf)
        begin
            r_bits_next = p & SIGN_BIT;
        end
        else
        begin
            r_bits_next = p;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rn_reg      <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            c_ovf_reg   <= 1'b0;
            c_unf_reg   <= 1'b0;
            s_ovf_reg   <= 1'b0;
            s_unf_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                rn_reg <= cfg.round_nearest;
            end
            if (advance)
            begin
                a_valid_reg <= operands.valid;
                b_valid_reg <= a_valid_reg;
                r_valid_reg <= b_valid_reg;
                if (b_valid_reg)
                begin
                    c_ovf_reg <= ovf;
                    if (ovf)
                    begin
                        s_ovf_reg <= 1'b1;
                    end
                    else
                    begin
                        c_unf_reg <= unf;
                        if (unf)
                        begin
                            s_unf_reg <= 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_s_reg      <= operands.operand_s;
            a_t_reg      <= operands.operand_t;
            b_prod_reg   <= prod_next;
            b_esum_reg   <= {1'b0, cs[30:23]} + {1'b0, ct[30:23]};
            b_zero_reg   <= (cs[30:23] == 8'd0) || (ct[30:23] == 8'd0);
            b_sign_reg   <= cs[31] ^ ct[31];
            b_defect_reg <= defective_t(ct[22:0]);
            r_bits_reg   <= r_bits_next;
        end
    end

    assign result.valid            = r_valid_reg;
    assign result.product_bits     = r_bits_reg;
    assign result.overflow_flag    = c_ovf_reg;
    assign result.underflow_flag   = c_unf_reg;
    assign result.overflow_sticky  = s_ovf_reg;
    assign result.underflow_sticky = s_unf_reg;

`ifndef SYNTH
    a_ovf_fmax: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && c_ovf_reg |-> r_bits_reg[30:0] == FMAX_BITS[30:0])
        else $error("overflow result is not Fmax");
    a_unf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg && c_unf_reg && !c_ovf_reg |-> r_bits_reg[30:0] == 31'd0)
        else $error("underflow result is not zero");
    a_sticky_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(s_ovf_reg) && !$fell(s_unf_reg))
        else $error("sticky flag cleared");
    a_cause_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (c_ovf_reg |-> s_ovf_reg) and (c_unf_reg |-> s_unf_reg))
        else $error("cause flag without sticky flag");
`endif

endmodule
`default_nettype wire

>>> bench/console_fp32_multiplier_unit_test.sv
// Self-checking bench for the console single-precision multiplier unit.
// Predicts products and overflow/underflow flags in a scoreboard class and drives
// the operand, result and config channels; depends on fpm_pkg and fpm_ifs.sv.
`default_nettype none
module console_fp32_multiplier_unit_test
    import fpm_pkg::*;
();

    typedef struct packed {
        logic [31:0] bits;
        logic        ovf;
        logic        unf;
        logic        ovf_st;
        logic        unf_st;
    } product_t;

    class product_board;
        product_t    pending[$];
        bit          nearest;
        bit          c_ovf, c_unf, s_ovf, s_unf;
        int          errors;
        int          checked;

        function logic [31:0] clamp(logic [31:0] x);
            logic [7:0] e;
            e = x[30:23];
            if (e == 8'd0)
                return {x[31], 31'd0};
            if (e == 8'hFF)
                return {x[31], 31'h7F7FFFFF};
            return x;
        endfunction

        function bit booth_defect(logic [22:0] m);
            logic [3:0] h;
            bit         band;
            h = m[15:12];
            band = (h >= 4'd8) && (h <= 4'd13);
            return ((m & 23'h2AA) != 0) || (m[11] != band);
        endfunction

        function logic [31:0] mul(logic [31:0] s, logic [31:0] t);
            logic        sg;
            logic [63:0] prod, keep, rem, half, mag;
            int          es, et, n, eb, sh;
            bit          tz;
            sg = s[31] ^ t[31];
            es = int'(s[30:23]);
            et = int'(t[30:23]);
            if (es == 0 || et == 0)
                return {sg, 31'd0};
            prod = {40'd0, 1'b1, s[22:0]} * {40'd0, 1'b1, t[22:0]};
            n = prod[47] ? 47 : 46;
            eb = n + es + et - 173;
            sh = n - 23;
            tz = (prod & ((64'd1 << sh) - 1)) == 0;
            if (eb < 1)
                sh += 1 - eb;
            if (sh >= 49)
                mag = 0;
            else
            begin
                keep = prod >> sh;
                rem = prod & ((64'd1 << sh) - 1);
                half = 64'd1 << (sh - 1);
                if (nearest && (rem > half || (rem == half && keep[0])))
                    keep += 1;
                mag = (eb >= 1) ? ((64'(eb - 1) << 23) + keep) : keep;
            end
            if (mag >= 64'h7F800000)
                return {sg, nearest ? 31'h7F800000 : 31'h7F7FFFFF};
            if (tz && eb >= 1 && eb <= 254 && mag != 64'h00800000 && booth_defect(t[22:0]))
                mag -= 1;
            return {sg, mag[30:0]};
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            logic [31:0] p;
            product_t    x;
            p = mul(clamp(a), clamp(b));
            if (p[30:0] == INF_BITS[30:0])
            begin
                p = {p[31], FMAX_BITS[30:0]};
                c_ovf = 1;
                s_ovf = 1;
            end
            else
            begin
                c_ovf = 0;
                if (p[30:23] == 0 && p[22:0] != 0)
                begin
                    p = {p[31], 31'd0};
                    c_unf = 1;
                    s_unf = 1;
                end
                else
                    c_unf = 0;
            end
            x = '{p, c_ovf, c_unf, s_ovf, s_unf};
            pending.push_back(x);
        endfunction

        function void check_product(product_t got);
            product_t e;
            checked++;
            if (pending.size() == 0)
            begin
                $display("%0t unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                $display("%0t mismatch: expected bits %h ovf %b unf %b sov %b sun %b",
                         $time, e.bits, e.ovf, e.unf, e.ovf_st, e.unf_st);
                $display("%0t           actual   bits %h ovf %b unf %b sov %b sun %b",
                         $time, got.bits, got.ovf, got.unf, got.ovf_st, got.unf_st);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    int   send_idle, recv_idle;
    int   sent;
    product_board board = new();

    fpm_operand_if operands();
    fpm_result_if  result();
    fpm_cfg_if     cfg();

    console_fp32_multiplier_unit dut (
        .clk(clk), .rst_n(rst_n), .operands(operands.sink),
        .result(result.source), .cfg(cfg.sink)
    );

    always
    begin
        #6 clk = 1;
        #6 clk = 0;
    end

    initial
    begin
        #2000000;
        $display("FAIL console_fp32_multiplier_unit");
        $finish;
    end

    initial
    begin
        result.ready = 0;
        @(negedge clk);
        forever
        begin
            result.ready <= ($urandom_range(99) >= recv_idle);
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
                board.check_product('{result.product_bits, result.overflow_flag,
                    result.underflow_flag, result.overflow_sticky, result.underflow_sticky});
            @(negedge clk);
        end
    end

    task automatic send_pair(logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle)
        begin
            operands.valid <= 0;
            @(negedge clk);
        end
        operands.valid <= 1;
        operands.operand_s <= a;
        operands.operand_t <= b;
        do
            @(posedge clk);
        while (!operands.ready);
        board.note_operands(a, b);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        operands.valid <= 0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_mode(bit nearest);
        cfg.valid <= 1;
        cfg.round_nearest <= nearest;
        do
            @(posedge clk);
        while (!cfg.ready);
        board.nearest = nearest;
        @(negedge clk);
        cfg.valid <= 0;
    endtask

    function automatic logic [31:0] rand_float();
        logic [31:0] x;
        x = $urandom;
        case ($urandom_range(7))
            0: x[30:23] = 8'd0;
            1: x[30:23] = 8'hFF;
            2: x[30:23] = 8'($urandom_range(200, 254));
            3: x[30:23] = 8'($urandom_range(1, 60));
            4: x[22:0] = {8'($urandom_range(255)), 15'd0};
            default: ;
        endcase
        return x;
    endfunction

    task automatic random_phase(int count);
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = rand_float();
            send_pair(a, rand_float());
        end
    endtask

    initial
    begin
        logic [31:0] corner[12];
        operands.valid = 0;
        operands.operand_s = 0;
        operands.operand_t = 0;
        cfg.valid = 0;
        cfg.round_nearest = 0;
        send_idle = 0;
        recv_idle = 0;
        sent = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        corner = '{32'h0, 32'h80000000, 32'h00000001, 32'h7F800000, 32'hFF800000,
                   32'h7F7FFFFF, 32'h00800000, 32'h3F800000, 32'hBF800000,
                   32'h3F801000, 32'h3FC00000, 32'h7FFFFFFF};
        for (int m = 0; m < 2; m++)
        begin
            write_mode(m[0]);
            for (int i = 0; i < 12; i++)
                send_pair(corner[i], corner[(i * 5 + 3) % 12]);
            send_pair(32'h00FFFFFF, 32'h3F000000);
            drain();
        end
        write_mode(0);
        send_idle = 6;
        recv_idle = 45;
        random_phase(320);
        drain();
        write_mode(1);
        send_idle = 45;
        recv_idle = 6;
        random_phase(320);
        drain();
        write_mode(0);
        send_idle = 0;
        recv_idle = 0;
        random_phase(280);
        drain();
        $display("Sent %0d operand pairs in both rounding modes, %0d results checked.",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS console_fp32_multiplier_unit");
        else
            $display("FAIL console_fp32_multiplier_unit");
        $finish;
    end
endmodule
`default_nettype wire
